>>> src/sparse_poly_add_merge_assert.svh
// Assertion macros shared by the checker of the sparse polynomial merge block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef SPARSE_POLY_ADD_MERGE_ASSERT_SVH
`define SPARSE_POLY_ADD_MERGE_ASSERT_SVH

// Antecedent holds in a cycle, so the consequent holds in the same cycle.
`define SPADD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds in a cycle, so the consequent holds in the next cycle.
`define SPADD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/spadd_pkg.sv
// Package of the sparse polynomial merge block: item types, codes and sizes.
// Used by the merge sequencer, the top level and the checker of the block.
`default_nettype none

package spadd_pkg;

    localparam int DEPTH_DEF  = 32;
    localparam int COEF_W     = 32;
    localparam int EXP_W      = 16;
    localparam int OUT_COEF_W = COEF_W + 1;

    localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
    localparam logic [1:0] CMD_MERGE       = 2'd2;

    typedef struct packed {
        logic [1:0]              cmd;
        logic signed [COEF_W-1:0] term_coef;
        logic [EXP_W-1:0]        term_exp;
    } spadd_in_t;

    typedef struct packed {
        logic signed [OUT_COEF_W-1:0] out_coef;
        logic [EXP_W-1:0]             out_exp;
        logic                         last;
        logic                         empty_res;
        logic                         overflow;
    } spadd_out_t;

    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic [EXP_W-1:0]  ex;
    } spadd_term_t;

    localparam int TERM_W = $bits(spadd_term_t);

    typedef struct packed {
        logic idle;
        logic finish;
    } spadd_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FINISH
    } spadd_state_t;

endpackage

`default_nettype wire

>>> src/spadd_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Self-contained; used for both term stores of the merge block.
`default_nettype none

module spadd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/spadd_merge.sv
// Merge sequencer: walks both term stores, combines terms and drives the result register.
// Depends on spadd_pkg; reads the stores through their registered read ports.
`default_nettype none

module spadd_merge import spadd_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [CW-1:0] cnt_a,
    input  wire logic [CW-1:0] cnt_b,
    input  wire logic        dropped,
    output logic [AW-1:0]    raddr_a,
    output logic [AW-1:0]    raddr_b,
    input  wire spadd_term_t rdata_a,
    input  wire spadd_term_t rdata_b,
    output spadd_stat_t      stat,
    output logic             m_valid,
    input  wire logic        m_ready,
    output spadd_out_t       m_data
);

    spadd_state_t state_reg, state_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic signed [OUT_COEF_W-1:0] pend_coef_reg, pend_coef_next;
    logic [EXP_W-1:0]             pend_exp_reg, pend_exp_next;
    logic       m_valid_reg, m_valid_next;
    spadd_out_t m_data_reg, m_data_next;

    logic                         a_ok, b_ok, walk_done;
    logic                         take_a, take_b, take_both;
    logic                         cand_valid;
    logic signed [OUT_COEF_W-1:0] coef_a, coef_b, coef_sum, cand_coef;
    logic [EXP_W-1:0]             cand_exp;
    logic                         out_free, eval_stall;

    assign raddr_a = i_reg[AW-1:0];
    assign raddr_b = j_reg[AW-1:0];
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign out_free = !m_valid_reg || m_ready;

    assign a_ok      = i_reg < cnt_a;
    assign b_ok      = j_reg < cnt_b;
    assign walk_done = !a_ok && !b_ok;
    assign coef_a    = OUT_COEF_W'(signed'(rdata_a.coef));
    assign coef_b    = OUT_COEF_W'(signed'(rdata_b.coef));
    assign coef_sum  = coef_a + coef_b;

    always_comb begin
        take_a    = 1'b0;
        take_b    = 1'b0;
        take_both = 1'b0;
        priority if (a_ok && b_ok && rdata_a.ex == rdata_b.ex) begin
            take_both = 1'b1;
        end else if (a_ok && (!b_ok || rdata_a.ex > rdata_b.ex)) begin
            take_a = 1'b1;
        end else if (b_ok) begin
            take_b = 1'b1;
        end
    end

    always_comb begin
        cand_valid = 1'b0;
        cand_coef  = coef_b;
        cand_exp   = rdata_b.ex;
        priority if (take_both) begin
            cand_valid = coef_sum != '0;
            cand_coef  = coef_sum;
        end else if (take_a) begin
            cand_valid = 1'b1;
            cand_coef  = coef_a;
            cand_exp   = rdata_a.ex;
        end else if (take_b) begin
            cand_valid = 1'b1;
        end
    end

    assign eval_stall = cand_valid && pend_valid_reg && !out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (walk_done) begin
                    state_next = ST_FINISH;
                end else if (!eval_stall) begin
                    state_next = ST_READ;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        i_next          = i_reg;
        j_next          = j_reg;
        pend_valid_next = pend_valid_reg;
        pend_coef_next  = pend_coef_reg;
        pend_exp_next   = pend_exp_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        stat.idle       = 1'b0;
        stat.finish     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                stat.idle = 1'b1;
                if (start) begin
                    i_next          = '0;
                    j_next          = '0;
                    pend_valid_next = 1'b0;
                end
            end
            ST_READ: begin
            end
            ST_EVAL: begin
                if (!walk_done && !eval_stall) begin
                    if (take_a || take_both) begin
                        i_next = i_reg + 1'b1;
                    end
                    if (take_b || take_both) begin
                        j_next = j_reg + 1'b1;
                    end
                    if (cand_valid) begin
                        if (pend_valid_reg) begin
                            m_valid_next         = 1'b1;
                            m_data_next.out_coef  = pend_coef_reg;
                            m_data_next.out_exp   = pend_exp_reg;
                            m_data_next.last      = 1'b0;
                            m_data_next.empty_res = 1'b0;
                            m_data_next.overflow  = dropped;
                        end
                        pend_valid_next = 1'b1;
                        pend_coef_next  = cand_coef;
                        pend_exp_next   = cand_exp;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    stat.finish           = 1'b1;
                    pend_valid_next       = 1'b0;
                    m_valid_next          = 1'b1;
                    m_data_next.last      = 1'b1;
                    m_data_next.overflow  = dropped;
                    m_data_next.empty_res = !pend_valid_reg;
                    m_data_next.out_coef  = pend_valid_reg ? pend_coef_reg : '0;
                    m_data_next.out_exp   = pend_valid_reg ? pend_exp_reg : '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_coef_reg <= pend_coef_next;
        pend_exp_reg  <= pend_exp_next;
        m_data_reg    <= m_data_next;
    end

endmodule

`default_nettype wire

>>> src/sparse_poly_add_merge.sv
// Top level of the sparse polynomial merge block: term loading, counts and the two stores.
// Depends on spadd_pkg, spadd_ram and spadd_merge.
//
// A load item (first or second polynomial) writes one term to its store; a load into
// a full store drops the term and sets the sticky overflow flag.
// A merge item walks both stores, each step passing through a read state and then an
// evaluate state because each store is a RAM with a registered read: the read is
// issued, then the two terms are compared and combined. Each step takes one term from
// either list, a matched pair counting once; a step can wait while the result channel
// stalls, and no input item is taken until the merge's final item is handed to the
// result register. Items arrive in exponent merge order with last on the final one, or
// as a single empty_res item; both stores are empty afterward. Command value 3 is
// taken and ignored.
`default_nettype none

module sparse_poly_add_merge import spadd_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire spadd_in_t  s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output spadd_out_t      m_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic          dropped_reg, dropped_next;

    spadd_stat_t   stat;
    logic          accept, load_a, load_b, start;
    logic          we_a, we_b;
    logic [AW-1:0] raddr_a, raddr_b;
    spadd_term_t   wterm, rdata_a, rdata_b;

    assign s_ready = stat.idle;
    assign accept  = s_valid && s_ready;
    assign load_a  = accept && s_data.cmd == CMD_LOAD_FIRST;
    assign load_b  = accept && s_data.cmd == CMD_LOAD_SECOND;
    assign start   = accept && s_data.cmd == CMD_MERGE;
    assign we_a    = load_a && cnt_a_reg < CW'(DEPTH);
    assign we_b    = load_b && cnt_b_reg < CW'(DEPTH);

    assign wterm.coef = s_data.term_coef;
    assign wterm.ex   = s_data.term_exp;

    always_comb begin
        cnt_a_next   = cnt_a_reg;
        cnt_b_next   = cnt_b_reg;
        dropped_next = dropped_reg;
        if (stat.finish) begin
            cnt_a_next = '0;
            cnt_b_next = '0;
        end
        if (we_a) begin
            cnt_a_next = cnt_a_reg + 1'b1;
        end
        if (we_b) begin
            cnt_b_next = cnt_b_reg + 1'b1;
        end
        if ((load_a && !we_a) || (load_b && !we_b)) begin
            dropped_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_a_reg   <= '0;
            cnt_b_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            cnt_a_reg   <= cnt_a_next;
            cnt_b_reg   <= cnt_b_next;
            dropped_reg <= dropped_next;
        end
    end

    spadd_ram #(
        .WIDTH (TERM_W),
        .DEPTH (DEPTH)
    ) u_store_a (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (cnt_a_reg[AW-1:0]),
        .wdata (wterm),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    spadd_ram #(
        .WIDTH (TERM_W),
        .DEPTH (DEPTH)
    ) u_store_b (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (cnt_b_reg[AW-1:0]),
        .wdata (wterm),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    spadd_merge #(
        .DEPTH (DEPTH)
    ) u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .cnt_a   (cnt_a_reg),
        .cnt_b   (cnt_b_reg),
        .dropped (dropped_reg),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

>>> src/spadd_checker.sv
// Port-level checker for the sparse polynomial merge block, bound to its top level.
// Depends on spadd_pkg and the assertion macros in sparse_poly_add_merge_assert.svh.
`default_nettype none

`include "sparse_poly_add_merge_assert.svh"

module spadd_checker import spadd_pkg::*; (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire spadd_in_t  s_data,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire spadd_out_t m_data
);

    `SPADD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result item changed while stalled")

    `SPADD_ASSERT_SAME(a_empty_form, aclk, aresetn, m_valid && m_data.empty_res, m_data.last && m_data.out_coef == '0 && m_data.out_exp == '0, "empty result item is malformed")

    `SPADD_ASSERT_NEXT(a_merge_busy, aclk, aresetn, s_valid && s_ready && s_data.cmd == CMD_MERGE, !s_ready, "input taken during a merge")

    `SPADD_ASSERT_NEXT(a_overflow_sticky, aclk, aresetn, m_valid && m_ready && m_data.overflow, !m_valid || m_data.overflow, "overflow flag cleared without reset")

endmodule

bind sparse_poly_add_merge spadd_checker u_spadd_checker (.*);

`default_nettype wire
